// ----- rtl/angular_occlusion_test_macros.svh -----
// Assertion macros used by the angular occlusion test back part.
`ifndef ANGULAR_OCCLUSION_TEST_MACROS_SVH
`define ANGULAR_OCCLUSION_TEST_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AOT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define AOT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/aot_pkg.sv -----
// Types and constants shared by the angular occlusion test modules.
`timescale 1ns / 1ps

package aot_pkg;

   localparam int FRAC_ONE = 256;

   // verdict codes
   localparam logic [1:0] VERDICT_VISIBLE  = 2'd0;
   localparam logic [1:0] VERDICT_OCCLUDED = 2'd1;
   localparam logic [1:0] VERDICT_BEYOND   = 2'd2;

   // request types
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_TEST  = 1'b1;

   // register indexes
   localparam logic CSR_CULL_ENABLE   = 1'b0;
   localparam logic CSR_CULL_DISTANCE = 1'b1;

   localparam logic [18:0] RAY_RESET      = 19'd512;
   localparam logic [18:0] CULL_DIST_INIT = 19'd65536;

   typedef enum logic [1:0] {
      JOB_WRITE  = 2'd0,
      JOB_ANSWER = 2'd1,
      JOB_TEST   = 2'd2
   } job_kind_type;

   // one slope quotient to work out: num/den in Q.8, then fixed up
   typedef struct packed {
      logic [21:0] num;
      logic [21:0] den;
      logic        comp;  // result is 2 - q
      logic        neg;   // result is negated
      logic        sat;   // quotient known to exceed 4
      logic [2:0]  off;   // whole units added to the pseudo-angle
   } ang_type;

   typedef struct packed {
      job_kind_type       kind;
      logic [1:0]         verdict;
      logic [7:0]         ray_index;
      logic [18:0]        ray_dist;
      logic signed [21:0] man_dist;
      ang_type            ang_h;
      ang_type            ang_l;
   } job_type;

   typedef struct packed {
      logic        enable;
      logic [18:0] distance;
   } cfg_type;

endpackage

// ----- rtl/aot_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module aot_ram #(
   parameter int WIDTH = 19,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/aot_queue.sv -----
// Two-entry job queue between the front and back parts.
`timescale 1ns / 1ps

module aot_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  aot_pkg::job_type din,
   output logic             full,
   input  logic             pop,
   output aot_pkg::job_type dout,
   output logic             valid
);

   aot_pkg::job_type slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = count_ff == 2'd2;
   assign valid   = count_ff != 2'd0;
   assign dout    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// ----- rtl/aot_front.sv -----
// Front part: takes request beats, clamps, range-checks and sets up slope jobs.
`timescale 1ns / 1ps

module aot_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_type,
   input  logic [7:0]         req_ray_index,
   input  logic [18:0]        req_ray_dist,
   input  logic signed [18:0] req_viewer_x,
   input  logic signed [18:0] req_viewer_y,
   input  logic signed [18:0] req_cell_x,
   input  logic signed [18:0] req_cell_y,
   input  logic [10:0]        req_cell_size,
   input  aot_pkg::cfg_type   cfg,
   input  logic               hold,
   input  logic               q_full,
   output aot_pkg::job_type   job,
   output logic               job_valid
);

   logic               stg_valid_ff, stg_valid_in;
   logic               stg_type_ff;
   logic [7:0]         stg_index_ff;
   logic [18:0]        stg_dist_ff;
   logic signed [18:0] stg_vx_ff, stg_vy_ff, stg_cx_ff, stg_cy_ff;
   logic [10:0]        stg_size_ff;
   logic               accept;

   // Builds the quotient job for one octant ratio or one signed slope.
   function automatic aot_pkg::ang_type ang_desc(input logic is_oct,
                                                 input logic signed [21:0] x,
                                                 input logic signed [21:0] y,
                                                 input logic [2:0] off);
      aot_pkg::ang_type d;
      logic [21:0]      ax, ay;
      ax = x[21] ? 22'(-x) : 22'(x);
      ay = y[21] ? 22'(-y) : 22'(y);
      d.off  = off;
      d.neg  = 1'b0;
      d.sat  = 1'b0;
      d.comp = 1'b0;
      if (is_oct) begin
         if (x > y) begin
            d.num = 22'(y);
            d.den = 22'(x);
         end else begin
            d.num  = 22'(x);
            d.den  = 22'(y);
            d.comp = 1'b1;
         end
      end else begin
         d.num = ay;
         d.den = ax;
         d.neg = x[21] ^ y[21];
         d.sat = {2'b00, ay} > {ax, 2'b00};
      end
      return d;
   endfunction

   assign req_full  = hold || (stg_valid_ff && q_full);
   assign accept    = req_push && !req_full;
   assign job_valid = stg_valid_ff;

   // input stage
   always_comb begin
      stg_valid_in = stg_valid_ff;
      if (accept) begin
         stg_valid_in = 1'b1;
      end else if (stg_valid_ff && !q_full) begin
         stg_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stg_type_ff  <= req_type;
         stg_index_ff <= req_ray_index;
         stg_dist_ff  <= req_ray_dist;
         stg_vx_ff    <= req_viewer_x;
         stg_vy_ff    <= req_viewer_y;
         stg_cx_ff    <= req_cell_x;
         stg_cy_ff    <= req_cell_y;
         stg_size_ff  <= req_cell_size;
      end
   end

   // classify the staged beat
   always_comb begin
      logic signed [21:0] vx, vy, cx, cy, cx2, cy2, cs, nx, ny, dx, dy, xd, yd;
      logic               beyond;
      vx  = 22'(stg_vx_ff);
      vy  = 22'(stg_vy_ff);
      cx  = 22'(stg_cx_ff);
      cy  = 22'(stg_cy_ff);
      cs  = $signed({3'b000, stg_size_ff, 8'd0});
      cx2 = cx + cs;
      cy2 = cy + cs;
      nx  = (vx < cx) ? cx : ((vx > cx2) ? cx2 : vx);
      ny  = (vy < cy) ? cy : ((vy > cy2) ? cy2 : vy);
      dx  = nx - vx;
      dy  = ny - vy;
      xd  = dx[21] ? -dx : dx;
      yd  = dy[21] ? -dy : dy;
      beyond = (xd > $signed({3'b000, cfg.distance}))
            || (yd > $signed({3'b000, cfg.distance}));

      job.ray_index = stg_index_ff;
      job.ray_dist  = stg_dist_ff;
      job.man_dist  = xd + yd - 22'sd256;
      job.verdict   = aot_pkg::VERDICT_VISIBLE;
      job.kind      = aot_pkg::JOB_TEST;
      job.ang_h     = ang_desc(1'b1, 22'sd1, 22'sd1, 3'd0);
      job.ang_l     = job.ang_h;

      // which side of the cell the viewer sits on
      if (cx <= vx) begin
         if (cx2 < vx) begin
            if (cy <= vy) begin
               if (cy2 < vy) begin
                  job.ang_h = ang_desc(1'b1, vx - cx, vy - cy2, 3'd4);
                  job.ang_l = ang_desc(1'b1, vx - cx2, vy - cy, 3'd4);
               end else begin
                  job.ang_h = ang_desc(1'b0, vx - cx2, vy - cy2, 3'd4);
                  job.ang_l = ang_desc(1'b0, vx - cx2, vy - cy, 3'd4);
               end
            end else begin
               job.ang_h = ang_desc(1'b1, cy2 - vy, vx - cx2, 3'd2);
               job.ang_l = ang_desc(1'b1, cy - vy, vx - cx, 3'd2);
            end
         end else begin
            if (cy <= vy) begin
               if (cy2 < vy) begin
                  job.ang_h = ang_desc(1'b0, vy - cy2, cx - vx, 3'd6);
                  job.ang_l = ang_desc(1'b0, vy - cy2, cx2 - vx, 3'd6);
               end else begin
                  // viewer over the cell
                  job.kind = aot_pkg::JOB_ANSWER;
               end
            end else begin
               job.ang_h = ang_desc(1'b0, cy - vy, vx - cx2, 3'd2);
               job.ang_l = ang_desc(1'b0, cy - vy, vx - cx, 3'd2);
            end
         end
      end else begin
         if (cy <= vy) begin
            if (cy2 < vy) begin
               job.ang_h = ang_desc(1'b1, vy - cy, cx - vx, 3'd6);
               job.ang_l = ang_desc(1'b1, vy - cy2, cx2 - vx, 3'd6);
            end else begin
               job.ang_h = ang_desc(1'b0, cx - vx, cy - vy, 3'd0);
               job.ang_l = ang_desc(1'b0, cx - vx, cy2 - vy, 3'd0);
            end
         end else begin
            job.ang_h = ang_desc(1'b1, cx2 - vx, cy - vy, 3'd0);
            job.ang_l = ang_desc(1'b1, cx - vx, cy2 - vy, 3'd0);
         end
      end

      if (beyond) begin
         job.kind    = aot_pkg::JOB_ANSWER;
         job.verdict = aot_pkg::VERDICT_BEYOND;
      end
      if (!cfg.enable) begin
         job.kind    = aot_pkg::JOB_ANSWER;
         job.verdict = aot_pkg::VERDICT_VISIBLE;
      end
      if (stg_type_ff == aot_pkg::REQ_WRITE) begin
         job.kind = aot_pkg::JOB_WRITE;
      end
   end

endmodule

// ----- rtl/aot_back.sv -----
// Back part: ray table, shared divider, span scan and result register.
`timescale 1ns / 1ps
`include "angular_occlusion_test_macros.svh"

module aot_back #(
   parameter int NUM_RAYS = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  aot_pkg::job_type job,
   input  logic             job_valid,
   output logic             job_take,
   output logic             clearing,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [1:0]       rsp_verdict
);

   localparam int AW = $clog2(NUM_RAYS);
   localparam int IW = $clog2(3 * NUM_RAYS + 4);
   localparam int PW = 14 + $clog2(NUM_RAYS + 1);

   typedef enum logic [7:0] {
      S_CLEAR = 8'b00000001,
      S_IDLE  = 8'b00000010,
      S_WRITE = 8'b00000100,
      S_LOAD  = 8'b00001000,
      S_DIV   = 8'b00010000,
      S_INDEX = 8'b00100000,
      S_SCAN  = 8'b01000000,
      S_DONE  = 8'b10000000
   } state_type;

   state_type          state_ff, state_in;
   aot_pkg::job_type   job_ff;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [7:0]         widx_ff, widx_in;
   logic               sel_ff, sel_in;
   logic [3:0]         k_ff, k_in;
   logic [32:0]        rem_ff, rem_in;
   logic [22:0]        dsor_ff, dsor_in;
   logic [10:0]        quot_ff, quot_in;
   logic signed [12:0] ah_ff, ah_in, al_ff, al_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic [IW-1:0]      remain_ff, remain_in;
   logic               pend_ff, pend_in, last_ff, last_in;
   logic [1:0]         verdict_ff, verdict_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_verdict_ff;
   logic               rsp_load;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [18:0]        wr_data;
   logic [18:0]        rd_data;

   aot_ram #(.WIDTH(19), .DEPTH(NUM_RAYS)) u_ray_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // Final pseudo-angle from a quotient and its fix-up flags.
   function automatic logic signed [12:0] ang_value(input aot_pkg::ang_type d,
                                                    input logic [10:0] q);
      logic [9:0]         qs;
      logic [10:0]        v;
      logic signed [12:0] av;
      qs = (d.sat || q > 11'd512) ? 10'd512 : q[9:0];
      v  = d.comp ? 11'd512 - {1'b0, qs} : {1'b0, qs};
      av = d.neg ? -$signed({2'b00, v}) : $signed({2'b00, v});
      return $signed({2'b00, d.off, 8'd0}) + av;
   endfunction

   // Ray index (plus NUM_RAYS) for a pseudo-angle, rounded half up.
   function automatic logic [IW-1:0] ang_index(input logic signed [12:0] a);
      logic [13:0]   u;
      logic [PW-1:0] p;
      u = 14'($signed({a[12], a}) + 14'sd2048);
      p = PW'(u) * PW'(NUM_RAYS) + PW'(1024);
      return IW'(p >> 11);
   endfunction

   assign clearing    = state_ff == S_CLEAR;
   assign rsp_empty   = !rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;
   assign job_take    = (state_ff == S_IDLE) && job_valid;

   // sequencer
   always_comb begin
      aot_pkg::ang_type   ang;
      logic [32:0]        shifted;
      logic signed [12:0] a;
      logic [IW-1:0]      si, ei, s1;
      state_in     = state_ff;
      clr_in       = clr_ff;
      widx_in      = widx_ff;
      sel_in       = sel_ff;
      k_in         = k_ff;
      rem_in       = rem_ff;
      dsor_in      = dsor_ff;
      quot_in      = quot_ff;
      ah_in        = ah_ff;
      al_in        = al_ff;
      addr_in      = addr_ff;
      remain_in    = remain_ff;
      pend_in      = 1'b0;
      last_in      = 1'b0;
      verdict_in   = verdict_ff;
      rsp_load     = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = clr_ff;
      wr_data      = aot_pkg::RAY_RESET;
      ang          = sel_ff ? job_ff.ang_l : job_ff.ang_h;
      shifted      = 33'(dsor_ff) << k_ff;
      a            = '0;
      si           = ang_index(ah_ff);
      ei           = ang_index(al_ff) + IW'(1);
      s1           = '0;

      case (state_ff)
         S_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(NUM_RAYS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (job_valid) begin
               widx_in    = job.ray_index;
               verdict_in = job.verdict;
               sel_in     = 1'b0;
               case (job.kind)
                  aot_pkg::JOB_WRITE: state_in = S_WRITE;
                  aot_pkg::JOB_TEST:  state_in = S_LOAD;
                  default:            state_in = S_DONE;
               endcase
            end
         end
         S_WRITE: begin
            // index reduced modulo the table size
            if (32'(widx_ff) >= NUM_RAYS) begin
               widx_in = widx_ff - 8'(NUM_RAYS);
            end else begin
               wr_en    = 1'b1;
               wr_addr  = AW'(widx_ff);
               wr_data  = job_ff.ray_dist;
               state_in = S_IDLE;
            end
         end
         S_LOAD: begin
            rem_in   = {2'b00, ang.num, 9'd0} + 33'(ang.den);
            dsor_in  = {ang.den, 1'b0};
            quot_in  = '0;
            k_in     = 4'd10;
            state_in = S_DIV;
         end
         S_DIV: begin
            // one quotient bit per cycle
            if (rem_ff >= shifted) begin
               rem_in  = rem_ff - shifted;
               quot_in = quot_ff | (11'd1 << k_ff);
            end
            k_in = k_ff - 4'd1;
            if (k_ff == 4'd0) begin
               a = ang_value(ang, quot_in);
               if (sel_ff) begin
                  al_in    = a;
                  state_in = S_INDEX;
               end else begin
                  ah_in    = a;
                  sel_in   = 1'b1;
                  state_in = S_LOAD;
               end
            end
         end
         S_INDEX: begin
            if (ei <= si) begin
               ei = ei + IW'(NUM_RAYS);
            end
            s1        = (si >= IW'(NUM_RAYS)) ? si - IW'(NUM_RAYS) : si;
            s1        = (s1 >= IW'(NUM_RAYS)) ? s1 - IW'(NUM_RAYS) : s1;
            addr_in   = AW'(s1);
            remain_in = ei - si + IW'(1);
            state_in  = S_SCAN;
         end
         S_SCAN: begin
            if (remain_ff != '0) begin
               pend_in   = 1'b1;
               last_in   = remain_ff == IW'(1);
               remain_in = remain_ff - IW'(1);
               addr_in   = (addr_ff == AW'(NUM_RAYS - 1)) ? '0 : addr_ff + AW'(1);
            end
            if (pend_ff && (job_ff.man_dist < $signed({3'b000, rd_data}))) begin
               verdict_in = aot_pkg::VERDICT_VISIBLE;
               state_in   = S_DONE;
            end else if (pend_ff && last_ff) begin
               verdict_in = aot_pkg::VERDICT_OCCLUDED;
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_pop) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_take) begin
         job_ff <= job;
      end
      widx_ff    <= widx_in;
      sel_ff     <= sel_in;
      k_ff       <= k_in;
      rem_ff     <= rem_in;
      dsor_ff    <= dsor_in;
      quot_ff    <= quot_in;
      ah_ff      <= ah_in;
      al_ff      <= al_in;
      addr_ff    <= addr_in;
      remain_ff  <= remain_in;
      verdict_ff <= verdict_in;
      if (rsp_load) begin
         rsp_verdict_ff <= verdict_in;
      end
   end

   // checks
   `AOT_ASSERT_NOW(a_pend_from_scan, pend_ff, $past(state_ff) == S_SCAN, "read without scan")
   `AOT_ASSERT_NOW(a_rsp_from_done, $rose(rsp_valid_ff), $past(state_ff) == S_DONE, "stray result")
   `AOT_ASSERT_NOW(a_clear_quiet, state_ff == S_CLEAR, !rsp_valid_ff && !job_take, "busy in clear")
   `AOT_ASSERT_NEXT(a_take_leaves_idle, job_take, state_ff != S_IDLE, "job taken but idle")

endmodule

// ----- rtl/angular_occlusion_test.sv -----
// Top level of the angular occlusion test block.
`timescale 1ns / 1ps

// Angular occlusion test. Write beats (req_type 0) load one ray distance of
// the NUM_RAYS-entry occlusion table; test beats (req_type 1) give one verdict
// beat each. After reset the table is cleared to two units in one pass over
// all NUM_RAYS entries, during which req_full stays high. In the back part a
// write subtracts NUM_RAYS from an index past the table until it fits. A test
// that runs the full check sends its two slope quotients through one shared
// bit-serial divider, one after the other, and then scans the span one table
// read per cycle, stopping at the first ray farther than the cell. Culled,
// out-of-range and covering cells answer without the divider or the scan. The
// front part and a two-beat queue keep taking beats while the back part works.
module angular_occlusion_test #(
   parameter int NUM_RAYS = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_type,
   input  logic [7:0]         req_ray_index,
   input  logic [18:0]        req_ray_dist,
   input  logic signed [18:0] req_viewer_x,
   input  logic signed [18:0] req_viewer_y,
   input  logic signed [18:0] req_cell_x,
   input  logic signed [18:0] req_cell_y,
   input  logic [10:0]        req_cell_size,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [1:0]         rsp_verdict,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [18:0]        csr_data
);

   aot_pkg::cfg_type cfg_ff, cfg_in;
   aot_pkg::job_type f_job, q_job;
   logic             f_valid, q_full, q_valid, q_pop, clearing;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            aot_pkg::CSR_CULL_ENABLE:   cfg_in.enable   = csr_data[0];
            aot_pkg::CSR_CULL_DISTANCE: cfg_in.distance = csr_data;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable   <= 1'b1;
         cfg_ff.distance <= aot_pkg::CULL_DIST_INIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   aot_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_type      (req_type),
      .req_ray_index (req_ray_index),
      .req_ray_dist  (req_ray_dist),
      .req_viewer_x  (req_viewer_x),
      .req_viewer_y  (req_viewer_y),
      .req_cell_x    (req_cell_x),
      .req_cell_y    (req_cell_y),
      .req_cell_size (req_cell_size),
      .cfg           (cfg_ff),
      .hold          (clearing),
      .q_full        (q_full),
      .job           (f_job),
      .job_valid     (f_valid)
   );

   aot_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (f_valid),
      .din   (f_job),
      .full  (q_full),
      .pop   (q_pop),
      .dout  (q_job),
      .valid (q_valid)
   );

   aot_back #(.NUM_RAYS(NUM_RAYS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .job         (q_job),
      .job_valid   (q_valid),
      .job_take    (q_pop),
      .clearing    (clearing),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_verdict (rsp_verdict)
   );

endmodule
